FILE: rtl/mer_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mer_pkg
// Shared types and constants of the midpoint ellipse rasterizer.
// ----------------------------------------------------------------------------
package mer_pkg;

  localparam int COORD_BITS_DEF = 11;

  localparam int RAD_W      = 10;
  localparam int OFF_W      = 10;
  localparam int SQ_W       = 2 * RAD_W;
  localparam int DEC_W      = 48;
  localparam int PIX_W      = 13;
  localparam int MUL_W      = 22;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int CENTER_W   = 11;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 2'd3;

  typedef enum logic {
    OP_STEP,
    OP_RESTART
  } op_t;

  typedef struct packed {
    logic             done_beat;
    logic             fin;
    logic [OFF_W-1:0] x;
    logic [OFF_W-1:0] y;
  } emit_cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ_X,
    S_SQ_Y,
    S_SQ_END,
    S_RS_MUL,
    S_RS_ACC,
    S_ST_M1,
    S_ST_M2,
    S_ST_ACC,
    S_EN_T,
    S_EN_A,
    S_EN_YM,
    S_EN_B,
    S_EN_C,
    S_EN_D,
    S_EMIT
  } eng_state_t;

endpackage
`default_nettype wire

FILE: rtl/mer_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mer_in_if
// Step channel: one restart bit per beat.
// ----------------------------------------------------------------------------
interface mer_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface
`default_nettype wire

FILE: rtl/mer_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mer_out_if
// Pixel channel: one plotted point or status beat per transfer.
// ----------------------------------------------------------------------------
interface mer_out_if;
  import mer_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [PIX_W-1:0] pixel_x;
  logic signed [PIX_W-1:0] pixel_y;
  logic                    point_valid;
  logic                    last_of_run;
  logic                    finished;

  modport source (output valid, output pixel_x, output pixel_y, output point_valid,
                  output last_of_run, output finished, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input point_valid,
                  input last_of_run, input finished, output ready);
endinterface
`default_nettype wire

FILE: rtl/mer_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mer_front
// Accepts step beats, classifies them and queues them for the engine.
// ----------------------------------------------------------------------------
module mer_front (
  input  wire logic        clk,
  input  wire logic        rst,
  mer_in_if.sink           steps,
  output mer_pkg::op_t     q_op,
  output logic             q_valid,
  input  wire logic        q_pop
);
  import mer_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  op_t              entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             push;
  logic             pop;
  op_t              op_in;

  assign op_in       = steps.restart ? OP_RESTART : OP_STEP;
  assign steps.ready = (count != (PTR_W + 1)'(QUEUE_DEPTH));
  assign push        = steps.valid && steps.ready;
  assign q_valid     = (count != '0);
  assign pop         = q_pop && q_valid;
  assign q_op        = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= op_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/mer_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mer_engine
// Midpoint state and decision update on one shared registered multiplier.
// ----------------------------------------------------------------------------
module mer_engine (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [mer_pkg::RAD_W-1:0]   radius_x,
  input  wire logic [mer_pkg::RAD_W-1:0]   radius_y,
  input  wire logic                        radius_written,
  input  wire mer_pkg::op_t                q_op,
  input  wire logic                        q_valid,
  output logic                             q_pop,
  output mer_pkg::emit_cmd_t               cmd,
  output logic                             cmd_valid,
  input  wire logic                        cmd_ready
);
  import mer_pkg::*;

  eng_state_t        state;
  eng_state_t        state_next;

  logic [SQ_W-1:0]   rx2;
  logic [SQ_W-1:0]   ry2;
  logic              sq_ok;
  logic [OFF_W-1:0]  x;
  logic [OFF_W-1:0]  y;
  logic              region2;
  logic [DEC_W-1:0]  decision;
  logic              done_flag;
  logic              neg;
  logic              done_beat;
  logic [SQ_W+OFF_W-1:0] m1;
  logic [PROD_W-1:0] prod;
  logic [DEC_W-1:0]  acc;

  logic              mul_en;
  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic [PROD_W-1:0] mul_p;

  logic [DEC_W-1:0]  term_x;
  logic [DEC_W-1:0]  term_y;
  logic [DEC_W-1:0]  sq4x;
  logic [DEC_W-1:0]  sq4y;
  logic [DEC_W-1:0]  dec_step;
  logic              to_region2;
  logic [OFF_W:0]    t;
  logic [OFF_W-1:0]  ym;

  assign mul_p  = mul_a * mul_b;
  assign term_x = DEC_W'({m1, 3'b000});
  assign term_y = DEC_W'({prod[SQ_W+OFF_W-1:0], 3'b000});
  assign sq4x   = DEC_W'({rx2, 2'b00});
  assign sq4y   = DEC_W'({ry2, 2'b00});
  assign t      = {x, 1'b1};
  assign ym     = y - 1'b1;

  always_comb begin
    if (region2) begin
      dec_step = decision + (neg ? term_x : '0) - term_y + sq4x;
    end else begin
      dec_step = decision + term_x + sq4y - (neg ? '0 : term_y);
    end
  end

  assign to_region2 = !region2 && (m1 > prod[SQ_W+OFF_W-1:0]);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          if (!sq_ok) begin
            state_next = S_SQ_X;
          end else if (q_op == OP_RESTART) begin
            state_next = S_RS_MUL;
          end else if (done_flag) begin
            state_next = S_EMIT;
          end else begin
            state_next = S_ST_M1;
          end
        end
      end
      S_SQ_X:   state_next = S_SQ_Y;
      S_SQ_Y:   state_next = S_SQ_END;
      S_SQ_END: state_next = S_IDLE;
      S_RS_MUL: state_next = S_RS_ACC;
      S_RS_ACC: state_next = S_EMIT;
      S_ST_M1:  state_next = S_ST_M2;
      S_ST_M2:  state_next = S_ST_ACC;
      S_ST_ACC: begin
        if (y != '0 && to_region2) begin
          state_next = S_EN_T;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_EN_T:  state_next = S_EN_A;
      S_EN_A:  state_next = S_EN_YM;
      S_EN_YM: state_next = S_EN_B;
      S_EN_B:  state_next = S_EN_C;
      S_EN_C:  state_next = S_EN_D;
      S_EN_D:  state_next = S_EMIT;
      S_EMIT: begin
        if (cmd_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and multiplier operands
  always_comb begin
    q_pop     = 1'b0;
    cmd_valid = 1'b0;
    mul_en    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state)
      S_IDLE: q_pop = q_valid && sq_ok;
      S_SQ_X: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(radius_x);
        mul_b  = MUL_W'(radius_x);
      end
      S_SQ_Y: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(radius_y);
        mul_b  = MUL_W'(radius_y);
      end
      S_RS_MUL: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(rx2);
        mul_b  = MUL_W'(y);
      end
      S_ST_M1: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(ry2);
        mul_b  = MUL_W'(x);
      end
      S_ST_M2: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(rx2);
        mul_b  = MUL_W'(y);
      end
      S_EN_T: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(t);
        mul_b  = MUL_W'(t);
      end
      S_EN_A: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(ry2);
        mul_b  = prod[MUL_W-1:0];
      end
      S_EN_YM: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(ym);
        mul_b  = MUL_W'(ym);
      end
      S_EN_B: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(rx2);
        mul_b  = MUL_W'(prod[SQ_W-1:0]);
      end
      S_EN_C: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(rx2);
        mul_b  = MUL_W'(ry2);
      end
      S_EMIT: cmd_valid = 1'b1;
      default: begin
        q_pop     = 1'b0;
        cmd_valid = 1'b0;
      end
    endcase
  end

  assign cmd.done_beat = done_beat;
  assign cmd.fin       = done_flag;
  assign cmd.x         = x;
  assign cmd.y         = y;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= mul_p;
    end
    case (state)
      S_SQ_Y:   rx2 <= prod[SQ_W-1:0];
      S_SQ_END: ry2 <= prod[SQ_W-1:0];
      S_ST_M2:  m1  <= prod[SQ_W+OFF_W-1:0];
      S_EN_YM:  acc <= DEC_W'(prod);
      S_EN_C:   acc <= acc + DEC_W'({prod, 2'b00});
      default:  acc <= acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sq_ok     <= 1'b0;
      x         <= '0;
      y         <= '0;
      region2   <= 1'b0;
      decision  <= '0;
      done_flag <= 1'b1;
      neg       <= 1'b0;
      done_beat <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_SQ_END) begin
        sq_ok <= 1'b1;
      end
      if (radius_written) begin
        sq_ok <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid && sq_ok) begin
            if (q_op == OP_RESTART) begin
              done_beat <= 1'b0;
              x         <= '0;
              y         <= OFF_W'(radius_y);
              region2   <= 1'b0;
            end else if (done_flag) begin
              done_beat <= 1'b1;
            end else begin
              done_beat <= 1'b0;
              neg       <= decision[DEC_W-1];
              if (!region2 || decision[DEC_W-1]) begin
                x <= x + 1'b1;
              end
              if (region2 || !decision[DEC_W-1]) begin
                y <= y - 1'b1;
              end
            end
          end
        end
        S_RS_ACC: begin
          decision  <= sq4y - DEC_W'({prod, 2'b00}) + DEC_W'(rx2);
          done_flag <= (y == '0);
        end
        S_ST_ACC: begin
          decision <= dec_step;
          if (y == '0) begin
            done_flag <= 1'b1;
          end
        end
        S_EN_D: begin
          decision <= acc - DEC_W'({prod, 2'b00});
          region2  <= 1'b1;
        end
        default: begin
          decision <= decision;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/mer_emit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mer_emit
// Expands one engine result into its symmetric pixel beats.
// ----------------------------------------------------------------------------
module mer_emit #(
  parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [((COORD_BITS < mer_pkg::CENTER_W) ? COORD_BITS
                      : mer_pkg::CENTER_W)-1:0] center_x,
  input  wire logic [((COORD_BITS < mer_pkg::CENTER_W) ? COORD_BITS
                      : mer_pkg::CENTER_W)-1:0] center_y,
  input  wire mer_pkg::emit_cmd_t            cmd,
  input  wire logic                          cmd_valid,
  output logic                               cmd_ready,
  mer_out_if.source                          pixels
);
  import mer_pkg::*;

  emit_cmd_t        cur;
  logic             busy;
  logic [1:0]       beat_idx;
  logic             load;

  logic             ov;
  logic [PIX_W-1:0] px;
  logic [PIX_W-1:0] py;
  logic             pv;
  logic             last;
  logic             fin;

  logic [PIX_W-1:0] cx;
  logic [PIX_W-1:0] cy;
  logic [PIX_W-1:0] ox;
  logic [PIX_W-1:0] oy;

  assign cx = PIX_W'(center_x);
  assign cy = PIX_W'(center_y);
  assign ox = PIX_W'(cur.x);
  assign oy = PIX_W'(cur.y);

  assign cmd_ready = !busy;
  assign load      = busy && (!ov || pixels.ready);

  assign pixels.valid       = ov;
  assign pixels.pixel_x     = px;
  assign pixels.pixel_y     = py;
  assign pixels.point_valid = pv;
  assign pixels.last_of_run = last;
  assign pixels.finished    = fin;

  always_ff @(posedge clk) begin
    if (cmd_valid && !busy) begin
      cur <= cmd;
    end
    if (load) begin
      if (cur.done_beat) begin
        px   <= '0;
        py   <= '0;
        pv   <= 1'b0;
        last <= 1'b1;
        fin  <= 1'b1;
      end else begin
        px   <= beat_idx[0] ? cx - ox : cx + ox;
        py   <= beat_idx[1] ? cy - oy : cy + oy;
        pv   <= 1'b1;
        last <= (beat_idx == 2'd3);
        fin  <= cur.fin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      beat_idx <= '0;
      ov       <= 1'b0;
    end else begin
      if (cmd_valid && !busy) begin
        busy     <= 1'b1;
        beat_idx <= '0;
      end else if (load) begin
        beat_idx <= beat_idx + 1'b1;
        if (cur.done_beat || beat_idx == 2'd3) begin
          busy <= 1'b0;
        end
      end
      if (load) begin
        ov <= 1'b1;
      end else if (pixels.ready) begin
        ov <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/midpoint_ellipse_rasterizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer
// Four-way symmetric midpoint ellipse rasterizer, one step per input beat.
// ----------------------------------------------------------------------------
//   channel   dir  beat contents
//   steps     in   restart
//   pixels    out  pixel_x, pixel_y, point_valid, last_of_run, finished
//   cfg_*     in   write enable, register index, data
//
// A step runs dispatch, two multiplies, accumulate and hand-off; the step that
// enters region 2 adds the region-2 setup states, a restart runs one multiply
// and an accumulate, a step after the end goes straight to hand-off, and the
// first item after a radius write first squares the radii. All products go
// through one registered 22x22 multiplier. Each result leaves as 4 beats (1
// for a step after the end), overlapped with the next item's computation.
// Reset is synchronous; no clearing pass. A 4-entry queue holds step beats
// while the pixel side stalls.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer #(
  parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  mer_in_if.sink                                 steps,
  mer_out_if.source                              pixels,
  input  wire logic                              cfg_we,
  input  wire logic [mer_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mer_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mer_pkg::*;

  localparam int CW = (COORD_BITS < CENTER_W) ? COORD_BITS : CENTER_W;

  logic [RAD_W-1:0] radius_x;
  logic [RAD_W-1:0] radius_y;
  logic [CW-1:0]    center_x;
  logic [CW-1:0]    center_y;
  logic             radius_written;

  op_t              q_op;
  logic             q_valid;
  logic             q_pop;
  emit_cmd_t        cmd;
  logic             cmd_valid;
  logic             cmd_ready;

  assign radius_written = cfg_we &&
                          (cfg_index == REG_RADIUS_X || cfg_index == REG_RADIUS_Y);

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_x <= RAD_W'(1);
      radius_y <= RAD_W'(1);
      center_x <= '0;
      center_y <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RADIUS_X: radius_x <= cfg_data[RAD_W-1:0];
        REG_RADIUS_Y: radius_y <= cfg_data[RAD_W-1:0];
        REG_CENTER_X: center_x <= cfg_data[CW-1:0];
        REG_CENTER_Y: center_y <= cfg_data[CW-1:0];
        default:      radius_x <= radius_x;
      endcase
    end
  end

  mer_front u_front (
    .clk     (clk),
    .rst     (rst),
    .steps   (steps),
    .q_op    (q_op),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  mer_engine u_engine (
    .clk            (clk),
    .rst            (rst),
    .radius_x       (radius_x),
    .radius_y       (radius_y),
    .radius_written (radius_written),
    .q_op           (q_op),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .cmd            (cmd),
    .cmd_valid      (cmd_valid),
    .cmd_ready      (cmd_ready)
  );

  mer_emit #(
    .COORD_BITS (COORD_BITS)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .center_x  (center_x),
    .center_y  (center_y),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .pixels    (pixels)
  );

endmodule
`default_nettype wire

FILE: tb/tb_midpoint_ellipse_rasterizer.sv
// ----------------------------------------------------------------------------
// tb_midpoint_ellipse_rasterizer
// Self-checking bench for the four-way midpoint ellipse rasterizer.
// A directed table covers the reset state, the widest radii at the far
// corner, a flat ellipse with negative x, zero radii and a radius change
// between two steps of a running ellipse. Random restart/step runs under
// several register settings follow. Every accepted step beat goes through a
// bit-exact model of the stepper, and each pixel beat is checked in order.
// Both channels idle at random, and the pixel side holds off once for long
// enough to back the step channel up.
// ----------------------------------------------------------------------------
module tb_midpoint_ellipse_rasterizer;
  import mer_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLD_AT_BEAT   = 90;
  localparam int HOLD_CYCLES    = 160;
  localparam int MAX_REPORTS    = 10;
  localparam int RANDOM_PHASES  = 8;

  typedef struct packed {
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] py;
    logic             pv;
    logic             last;
    logic             fin;
  } pix_beat_t;

  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    op_t                   op;
    logic [2:0]            n_fixed;
    pix_beat_t [3:0]       fixed;
  } stim_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mer_in_if  step_ch ();
  mer_out_if pix_ch ();

  midpoint_ellipse_rasterizer dut (
    .clk       (clk),
    .rst       (rst),
    .steps     (step_ch.sink),
    .pixels    (pix_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ellipse tracer state
  logic [RAD_W-1:0]    ell_rx, ell_ry;
  logic [CENTER_W-1:0] ell_cx, ell_cy;
  logic [OFF_W-1:0]    ell_x, ell_y;
  logic                ell_r2;
  logic [DEC_W-1:0]    ell_dec;
  logic                ell_done;

  pix_beat_t step_beats[$];
  pix_beat_t pixel_expect_q[$];
  stim_row_t stim_rows[$];
  stim_row_t live_row;
  int        mismatches = 0;
  int        idle_cycles = 0;
  bit        quiet_side [2];

  function automatic pix_beat_t pt(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py,
                                   input logic last, input logic fin);
    pix_beat_t b;
    b.px   = px;
    b.py   = py;
    b.pv   = 1'b1;
    b.last = last;
    b.fin  = fin;
    return b;
  endfunction

  function automatic int draw_wait(input int side);
    if ($urandom_range(0, 24) == 0) quiet_side[side] = !quiet_side[side];
    return quiet_side[side] ? 0 : int'($urandom_range(0, 14));
  endfunction

  task automatic emit_quad();
    logic [PIX_W-1:0] cx, cy, ox, oy;
    cx = PIX_W'(ell_cx);
    cy = PIX_W'(ell_cy);
    ox = PIX_W'(ell_x);
    oy = PIX_W'(ell_y);
    step_beats.push_back(pt(cx + ox, cy + oy, 1'b0, ell_done));
    step_beats.push_back(pt(cx - ox, cy + oy, 1'b0, ell_done));
    step_beats.push_back(pt(cx + ox, cy - oy, 1'b0, ell_done));
    step_beats.push_back(pt(cx - ox, cy - oy, 1'b1, ell_done));
  endtask

  task automatic trace_ellipse_step(input logic rs);
    logic [63:0] rx2, ry2, xw, yw, t, ym, acc;
    logic        neg;
    step_beats.delete();
    rx2 = 64'(ell_rx) * 64'(ell_rx);
    ry2 = 64'(ell_ry) * 64'(ell_ry);
    if (rs) begin
      ell_x    = '0;
      ell_y    = ell_ry;
      ell_r2   = 1'b0;
      acc      = 64'd4 * ry2 - 64'd4 * rx2 * 64'(ell_ry) + rx2;
      ell_dec  = acc[DEC_W-1:0];
      ell_done = (ell_y == '0);
      emit_quad();
    end else if (ell_done) begin
      step_beats.push_back(pix_beat_t'{px: '0, py: '0, pv: 1'b0, last: 1'b1, fin: 1'b1});
    end else begin
      neg = ell_dec[DEC_W-1];
      acc = 64'(ell_dec);
      if (!ell_r2) begin
        ell_x = ell_x + 1'b1;
        if (!neg) ell_y = ell_y - 1'b1;
        xw  = 64'(ell_x);
        yw  = 64'(ell_y);
        acc = acc + 64'd8 * ry2 * xw + 64'd4 * ry2;
        if (!neg) acc = acc - 64'd8 * rx2 * yw;
        ell_dec = acc[DEC_W-1:0];
        if (ell_y == '0) begin
          ell_done = 1'b1;
        end else if (ry2 * xw > rx2 * yw) begin
          t       = 64'd2 * xw + 64'd1;
          ym      = yw - 64'd1;
          ell_r2  = 1'b1;
          acc     = ry2 * t * t + 64'd4 * rx2 * ym * ym - 64'd4 * rx2 * ry2;
          ell_dec = acc[DEC_W-1:0];
        end
      end else begin
        if (neg) ell_x = ell_x + 1'b1;
        ell_y = ell_y - 1'b1;
        xw    = 64'(ell_x);
        yw    = 64'(ell_y);
        if (neg) acc = acc + 64'd8 * ry2 * xw;
        acc     = acc - 64'd8 * rx2 * yw + 64'd4 * rx2;
        ell_dec = acc[DEC_W-1:0];
        if (ell_y == '0) ell_done = 1'b1;
      end
      emit_quad();
    end
  endtask

  task automatic check_pixel_beat();
    pix_beat_t got, want;
    got.px   = pix_ch.pixel_x;
    got.py   = pix_ch.pixel_y;
    got.pv   = pix_ch.point_valid;
    got.last = pix_ch.last_of_run;
    got.fin  = pix_ch.finished;
    if (pixel_expect_q.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("unexpected pixel beat: x=%0d y=%0d pv=%0b last=%0b fin=%0b",
                 $signed(got.px), $signed(got.py), got.pv, got.last, got.fin);
    end else begin
      want = pixel_expect_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch: got (%0d,%0d) pv/last/fin %0b%0b%0b, want (%0d,%0d) %0b%0b%0b",
                   $signed(got.px), $signed(got.py), got.pv, got.last, got.fin,
                   $signed(want.px), $signed(want.py), want.pv, want.last, want.fin);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      ell_rx   = 10'd1;
      ell_ry   = 10'd1;
      ell_cx   = '0;
      ell_cy   = '0;
      ell_x    = '0;
      ell_y    = '0;
      ell_r2   = 1'b0;
      ell_dec  = '0;
      ell_done = 1'b1;
    end else begin
      if (pix_ch.valid && pix_ch.ready) check_pixel_beat();
      if (cfg_we) begin
        case (cfg_index)
          REG_RADIUS_X: ell_rx = cfg_data[RAD_W-1:0];
          REG_RADIUS_Y: ell_ry = cfg_data[RAD_W-1:0];
          REG_CENTER_X: ell_cx = cfg_data[CENTER_W-1:0];
          REG_CENTER_Y: ell_cy = cfg_data[CENTER_W-1:0];
          default: ;
        endcase
      end
      if (step_ch.valid && step_ch.ready) begin
        trace_ellipse_step(step_ch.restart);
        if (live_row.n_fixed != 3'd0) begin
          for (int k = 0; k < int'(live_row.n_fixed); k++)
            pixel_expect_q.push_back(live_row.fixed[k]);
        end else begin
          foreach (step_beats[k]) pixel_expect_q.push_back(step_beats[k]);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((step_ch.valid && step_ch.ready) || (pix_ch.valid && pix_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic add_fixed(input op_t op, input logic [2:0] n, input pix_beat_t b0,
                           input pix_beat_t b1, input pix_beat_t b2, input pix_beat_t b3);
    stim_row_t r;
    r          = '0;
    r.op       = op;
    r.n_fixed  = n;
    r.fixed[0] = b0;
    r.fixed[1] = b1;
    r.fixed[2] = b2;
    r.fixed[3] = b3;
    stim_rows.push_back(r);
  endtask

  task automatic add_item(input op_t op);
    add_fixed(op, 3'd0, '0, '0, '0, '0);
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    stim_row_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    r.op     = OP_STEP;
    stim_rows.push_back(r);
  endtask

  task automatic build_directed();
    pix_beat_t done_b;
    done_b = pix_beat_t'{px: '0, py: '0, pv: 1'b0, last: 1'b1, fin: 1'b1};
    // out of reset: Rx = Ry = 1, centre at origin, nothing running
    add_fixed(OP_STEP, 3'd1, done_b, '0, '0, '0);
    add_fixed(OP_RESTART, 3'd4, pt(13'd0, 13'd1, 1'b0, 1'b0), pt(13'd0, 13'd1, 1'b0, 1'b0),
              pt(13'd0, 13'h1FFF, 1'b0, 1'b0), pt(13'd0, 13'h1FFF, 1'b1, 1'b0));
    add_item(OP_STEP);
    add_item(OP_STEP);
    // widest radii, bit 10 of the data dropped, centre in the far corner
    add_cfg(REG_RADIUS_X, 11'h7FF);
    add_cfg(REG_RADIUS_Y, 11'h7FF);
    add_cfg(REG_CENTER_X, 11'd2047);
    add_cfg(REG_CENTER_Y, 11'd2047);
    add_fixed(OP_RESTART, 3'd4, pt(13'd2047, 13'd3070, 1'b0, 1'b0),
              pt(13'd2047, 13'd3070, 1'b0, 1'b0), pt(13'd2047, 13'd1024, 1'b0, 1'b0),
              pt(13'd2047, 13'd1024, 1'b1, 1'b0));
    add_item(OP_STEP);
    add_item(OP_STEP);
    // flat ellipse at the origin, negative x
    add_cfg(REG_RADIUS_Y, 11'd1);
    add_cfg(REG_CENTER_X, 11'd0);
    add_cfg(REG_CENTER_Y, 11'd0);
    add_item(OP_RESTART);
    add_item(OP_STEP);
    add_item(OP_STEP);
    // Ry = 0 finishes on the restart
    add_cfg(REG_RADIUS_Y, 11'd0);
    add_fixed(OP_RESTART, 3'd4, pt(13'd0, 13'd0, 1'b0, 1'b1), pt(13'd0, 13'd0, 1'b0, 1'b1),
              pt(13'd0, 13'd0, 1'b0, 1'b1), pt(13'd0, 13'd0, 1'b1, 1'b1));
    add_fixed(OP_STEP, 3'd1, done_b, '0, '0, '0);
    // Rx = 0 goes to region 2 on the first step
    add_cfg(REG_RADIUS_X, 11'd0);
    add_cfg(REG_RADIUS_Y, 11'd3);
    add_item(OP_RESTART);
    repeat (4) add_item(OP_STEP);
    // radius changed between steps of a running ellipse
    add_cfg(REG_RADIUS_X, 11'd20);
    add_cfg(REG_RADIUS_Y, 11'd20);
    add_cfg(REG_CENTER_X, 11'd1000);
    add_cfg(REG_CENTER_Y, 11'd37);
    add_item(OP_RESTART);
    repeat (2) add_item(OP_STEP);
    add_cfg(REG_RADIUS_X, 11'd7);
    repeat (2) add_item(OP_STEP);
  endtask

  function automatic logic [CFG_DATA_W-1:0] draw_radius();
    logic [CFG_DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = CFG_DATA_W'(1);
      1:       v = CFG_DATA_W'(1023);
      2, 3:    v = CFG_DATA_W'($urandom_range(25, 1023));
      default: v = CFG_DATA_W'($urandom_range(1, 24));
    endcase
    v[CFG_DATA_W-1] = ($urandom_range(0, 3) == 0);
    return v;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] draw_center();
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return CFG_DATA_W'(2047);
      default: return CFG_DATA_W'($urandom_range(0, 2047));
    endcase
  endfunction

  task automatic build_random();
    logic [CFG_DATA_W-1:0] v;
    logic [RAD_W-1:0]      rx, ry;
    int                    run_left, n_items, cap;
    rx       = 10'd7;
    ry       = 10'd20;
    run_left = 0;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 0 || $urandom_range(0, 1) == 0) begin
        v  = draw_radius();
        rx = v[RAD_W-1:0];
        add_cfg(REG_RADIUS_X, v);
      end
      if (ph == 0 || $urandom_range(0, 1) == 0) begin
        v  = draw_radius();
        ry = v[RAD_W-1:0];
        add_cfg(REG_RADIUS_Y, v);
      end
      if (ph == 0 || $urandom_range(0, 1) == 0) add_cfg(REG_CENTER_X, draw_center());
      if (ph == 0 || $urandom_range(0, 1) == 0) add_cfg(REG_CENTER_Y, draw_center());
      n_items = int'($urandom_range(20, 32));
      for (int i = 0; i < n_items; i++) begin
        if (run_left == 0) begin
          add_item(OP_RESTART);
          cap      = int'(rx) + int'(ry) + 4;
          if (cap > 60) cap = 60;
          run_left = int'($urandom_range(1, cap));
        end else if ($urandom_range(0, 11) == 0) begin
          add_item(OP_RESTART);
        end else begin
          add_item(OP_STEP);
          run_left--;
        end
      end
    end
  endtask

  task automatic wait_drained();
    while (pixel_expect_q.size() != 0) @(negedge clk);
  endtask

  task automatic push_step(input stim_row_t row);
    int gap;
    gap = draw_wait(0);
    if (gap > 0) begin
      step_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    live_row = row;
    step_ch.valid   <= 1'b1;
    step_ch.restart <= row.op;
    @(posedge clk);
    while (!step_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_rows();
    bit cfg_open;
    cfg_open = 1'b0;
    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_cfg) begin
        if (!cfg_open) begin
          step_ch.valid <= 1'b0;
          wait_drained();
          cfg_open = 1'b1;
        end
        cfg_we    <= 1'b1;
        cfg_index <= stim_rows[i].idx;
        cfg_data  <= stim_rows[i].data;
        @(negedge clk);
      end else begin
        if (cfg_open) begin
          cfg_we   <= 1'b0;
          cfg_open = 1'b0;
        end
        push_step(stim_rows[i]);
      end
    end
    step_ch.valid <= 1'b0;
  endtask

  // pixel side: random stalls, one long hold-off to fill the step queue
  initial begin : pixel_sink
    int stall;
    int beats;
    pix_ch.ready = 1'b0;
    beats        = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = (beats == HOLD_AT_BEAT) ? HOLD_CYCLES : draw_wait(1);
      if (stall > 0) begin
        pix_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      pix_ch.ready <= 1'b1;
      @(posedge clk);
      while (!pix_ch.valid) @(posedge clk);
      beats++;
      @(negedge clk);
    end
  end

  initial begin
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    step_ch.valid   = 1'b0;
    step_ch.restart = 1'b0;
    live_row        = '0;
    build_directed();
    build_random();
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    run_rows();
    wait_drained();
    repeat (40) @(negedge clk);
    if (pixel_expect_q.size() != 0) begin
      $display("%0d expected pixel beats never arrived", pixel_expect_q.size());
      mismatches += pixel_expect_q.size();
    end
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
